// File: sv/spaq_pkg.sv
// shared types and codes of the sorted-array priority queue
package spaq_pkg;

   typedef enum logic {
      OP_INSERT  = 1'b0,
      OP_EXTRACT = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_INSERTED  = 2'd0,
      ST_EXTRACTED = 2'd1,
      ST_FULL      = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   typedef struct packed {
      logic               opcode;
      logic signed [31:0] data_in;
      logic signed [15:0] priority_in;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] data_out;
      logic signed [15:0] priority_out;
      logic [6:0]         occupancy;
   } rsp_type;

   typedef struct packed {
      logic               valid;
      logic signed [31:0] data;
      logic signed [15:0] prio;
   } entry_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic               insert;
      logic               extract;
      logic signed [31:0] data;
      logic signed [15:0] prio;
   } cell_ctrl_type;

endpackage

// File: sv/sorted_array_priority_queue.sv
// top level of the sorted-array priority queue, a chain of DEPTH cells
//
//   channel   ports                               direction
//   request   req_valid, req_stall, req_data      in  (req_stall out)
//   response  rsp_valid, rsp_stall, rsp_data      out (rsp_stall in)
//
// every transfer on the request side gives one response in the next cycle
// all cells compare against the new priority at once and shift together,
// so one item per cycle is taken while the response register drains
// reset empties the chain at once by clearing the cell valid bits
// a stalled response holds the request side until it is taken
module sorted_array_priority_queue #(
   parameter int DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  spaq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output spaq_pkg::rsp_type rsp_data
);
   import spaq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   logic              accept;
   logic              full, empty;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW+6:0]     occ_wide;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   cell_ctrl_type     ctrl;
   entry_type         cells [DEPTH];
   logic              keeps [DEPTH];
   entry_type         new_entry;
   entry_type         blank_entry;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);

   assign ctrl.insert  = accept && (req_data.opcode == OP_INSERT) && !full;
   assign ctrl.extract = accept && (req_data.opcode == OP_EXTRACT) && !empty;
   assign ctrl.data    = req_data.data_in;
   assign ctrl.prio    = req_data.priority_in;

   assign new_entry.valid   = 1'b1;
   assign new_entry.data    = req_data.data_in;
   assign new_entry.prio    = req_data.priority_in;
   assign blank_entry.valid = 1'b0;
   assign blank_entry.data  = '0;
   assign blank_entry.prio  = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type left_e, right_e;
      logic      left_k;
      if (i == 0) begin : g_head
         assign left_e = new_entry;
         assign left_k = 1'b0;
      end else begin : g_body
         assign left_e = cells[i-1];
         assign left_k = keeps[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign right_e = blank_entry;
      end else begin : g_inner
         assign right_e = cells[i+1];
      end
      spaq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_entry  (left_e),
         .left_keep   (left_k),
         .right_entry (right_e),
         .entry       (cells[i]),
         .keep        (keeps[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.insert) begin
         count_in = count_ff + CW'(1);
      end else if (ctrl.extract) begin
         count_in = count_ff - CW'(1);
      end
   end

   // occupancy field wraps at 128
   assign occ_wide = (CW+7)'(count_in);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (accept) begin
         rsp_valid_in          = 1'b1;
         rsp_in.data_out       = '0;
         rsp_in.priority_out   = '0;
         rsp_in.occupancy      = occ_wide[6:0];
         if (req_data.opcode == OP_INSERT) begin
            rsp_in.status = full ? ST_FULL : ST_INSERTED;
         end else if (empty) begin
            rsp_in.status = ST_EMPTY;
         end else begin
            rsp_in.status       = ST_EXTRACTED;
            rsp_in.data_out     = cells[0].data;
            rsp_in.priority_out = cells[0].prio;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_head_valid : assert property (@(posedge clock) disable iff (reset)
      cells[0].valid == !empty)
      else $error("head cell valid disagrees with entry count");

   a_tail_valid : assert property (@(posedge clock) disable iff (reset)
      cells[DEPTH-1].valid == full)
      else $error("tail cell valid disagrees with full");

   a_extract_rsp : assert property (@(posedge clock) disable iff (reset)
      ctrl.extract |=> rsp_valid_ff && (rsp_ff.status == ST_EXTRACTED)
                       && (rsp_ff.priority_out == $past(cells[0].prio)))
      else $error("extract transfer did not return the head entry");

endmodule

// File: sv/spaq_cell.sv
// one slot of the sorted chain: keeps, takes the new entry or shifts from a neighbor
module spaq_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  spaq_pkg::cell_ctrl_type ctrl,
   input  spaq_pkg::entry_type    left_entry,
   input  logic                   left_keep,
   input  spaq_pkg::entry_type    right_entry,
   output spaq_pkg::entry_type    entry,
   output logic                   keep
);
   import spaq_pkg::*;

   logic               valid_ff, valid_in;
   logic signed [31:0] data_ff, data_in;
   logic signed [15:0] prio_ff, prio_in;

   // entries at or above the new priority stay put, so ties leave in arrival order
   assign keep = valid_ff && (prio_ff >= ctrl.prio);

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      prio_in  = prio_ff;
      if (ctrl.extract) begin
         valid_in = right_entry.valid;
         data_in  = right_entry.data;
         prio_in  = right_entry.prio;
      end else if (ctrl.insert && !keep) begin
         valid_in = valid_ff | left_entry.valid;
         if (left_keep) begin
            data_in = ctrl.data;
            prio_in = ctrl.prio;
         end else begin
            data_in = left_entry.data;
            prio_in = left_entry.prio;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      prio_ff <= prio_in;
   end

   assign entry.valid = valid_ff;
   assign entry.data  = data_ff;
   assign entry.prio  = prio_ff;

endmodule
